### src/psch_pkg.sv
// ============================================================================
// psch_pkg : shared types for the priority scheduler
// Job record carried by the sorting cells, cell control group and the
// sequencer state encoding.
// ============================================================================
`default_nettype none

package psch_pkg;

  // Default job capacity of the sorting chain.
  localparam int MAX_JOBS_DEF = 16;

  // Job id storage width; covers the largest supported capacity (64).
  localparam int JOB_ID_W = 6;

  localparam int BURST_W  = 16;
  localparam int PRIO_W   = 8;
  localparam int OUT_ID_W = 4;
  localparam int TIME_W   = 20;
  localparam int AVG_W_W  = 27;
  localparam int AVG_T_W  = 28;

  // One job held by a cell.
  typedef struct packed {
    logic                valid;
    logic [PRIO_W-1:0]   prio;
    logic [BURST_W-1:0]  burst;
    logic [JOB_ID_W-1:0] id;
  } job_t;

  // Per-cycle command to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the new job, shift larger ones right
    logic shift;   // advance every cell toward the head
    logic clear;   // drop all held jobs
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EMIT,
    ST_DSTART,
    ST_DIV,
    ST_FINAL
  } sched_state_t;

endpackage

`default_nettype wire

### src/psch_cell.sv
// ============================================================================
// psch_cell : one slot of the sorted job chain
// Holds one job. On insert, takes the new job or the left neighbor's job so
// the chain stays ordered by priority with ties in arrival order. On shift,
// takes the right neighbor's job.
// ============================================================================
`default_nettype none

module psch_cell
  import psch_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire job_t      new_job,
  input  wire job_t      left_job,
  input  wire logic      left_gt,
  input  wire job_t      right_job,
  output job_t           job,
  output logic           gt
);

  job_t job_next;

  // Empty slots count as larger, so the new job lands at the first of them.
  assign gt = !job.valid || (job.prio > new_job.prio);

  always_comb begin
    job_next = job;
    if (ctl.clear) begin
      job_next.valid = 1'b0;
    end else if (ctl.insert) begin
      if (gt && !left_gt) begin
        job_next = new_job;
      end else if (gt) begin
        job_next = left_job;
      end
    end else if (ctl.shift) begin
      job_next = right_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job.valid <= 1'b0;
    end else begin
      job.valid <= job_next.valid;
    end
    job.prio  <= job_next.prio;
    job.burst <= job_next.burst;
    job.id    <= job_next.id;
  end

endmodule

`default_nettype wire

### src/psch_div.sv
// ============================================================================
// psch_div : restoring divider, one quotient bit per cycle
// Divides a DVD_W-bit dividend by a DVS_W-bit divisor.
// ============================================================================
`default_nettype none

module psch_div
  import psch_pkg::*;
#(
  parameter int DVD_W = 34,
  parameter int DVS_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] acc;   // dividend bits shift out, quotient bits shift in
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial    = {rem, acc[DVD_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      acc <= dividend;
    end else if (busy) begin
      rem <= fits ? DVS_W'(trial - {1'b0, divisor}) : DVS_W'(trial);
      acc <= {acc[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### src/priority_nonpreemptive_scheduler_top.sv
// ============================================================================
// priority_nonpreemptive_scheduler_top : non-preemptive priority scheduler
// Collects a batch of jobs in a sorted cell chain and emits them in
// ascending priority order with waiting, turnaround and average times.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | burst_time, priority_req, last_job
//  out     | out_valid / out_ready| job_id, job_priority, job_burst,
//          |                      | waiting_time, turnaround_time, avg_waiting,
//          |                      | avg_turnaround, overflow, last_result
//
//  Loading places each accepted request in its place in the chain in the
//  cycle it is accepted, or drops it and flags overflow if the chain is full.
//  Emitting loads the next result whenever the output register is empty or
//  out_ready is high; the final result waits for the average dividers,
//  bit-serial dividers that produce one quotient bit per cycle.
//  in_ready is low from the last_job request until the final result is
//  loaded into the output register. A stalled output holds the chain.
//  Reset clears the chain, counters and sequencer; nothing else is needed.
// ============================================================================
`default_nettype none

module priority_nonpreemptive_scheduler_top
  import psch_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [BURST_W-1:0]  burst_time,
  input  wire logic [PRIO_W-1:0]   priority_req,
  input  wire logic                last_job,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OUT_ID_W-1:0]      job_id,
  output logic [PRIO_W-1:0]        job_priority,
  output logic [BURST_W-1:0]       job_burst,
  output logic [TIME_W-1:0]        waiting_time,
  output logic [TIME_W-1:0]        turnaround_time,
  output logic [AVG_W_W-1:0]       avg_waiting,
  output logic [AVG_T_W-1:0]       avg_turnaround,
  output logic                     overflow,
  output logic                     last_result
);

  // Count, elapsed-time, sum and dividend widths all follow the capacity.
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int ELP_W = (BURST_W + CNT_W > TIME_W) ? BURST_W + CNT_W : TIME_W;
  localparam int SUM_W = ELP_W + CNT_W;
  localparam int DIV_W = SUM_W + 8;

  sched_state_t state, state_next;

  logic [CNT_W-1:0] job_count;
  logic             overflow_seen;
  logic [ELP_W-1:0] elapsed;
  logic [SUM_W-1:0] sum_wait;
  logic [SUM_W-1:0] sum_tat;

  // Chain wiring: entry MAX_JOBS is the permanently empty slot past the tail.
  job_t                chain [MAX_JOBS+1];
  logic [MAX_JOBS:0]   gt_vec;
  logic [MAX_JOBS-1:0] valid_vec;
  job_t                new_job;
  cell_ctl_t           ctl;

  logic             accept_in;
  logic             store;
  logic             slot_free;
  logic             last_one;
  logic             pop;
  logic             park;
  logic             div_start;
  logic             final_load;
  logic [ELP_W-1:0] head_tat;

  logic             div_busy_w;
  logic             div_busy_t;
  logic [DIV_W-1:0] quo_wait;
  logic [DIV_W-1:0] quo_tat;

  // --------------------------------------------------------------------------
  // Sorted cell chain
  // --------------------------------------------------------------------------
  assign new_job.valid = 1'b1;
  assign new_job.prio  = priority_req;
  assign new_job.burst = burst_time;
  assign new_job.id    = JOB_ID_W'(job_count);

  assign gt_vec[0]       = 1'b0;
  assign chain[MAX_JOBS] = '0;

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    job_t left_job;

    if (i == 0) begin : g_head
      assign left_job = new_job;
    end else begin : g_body
      assign left_job = chain[i-1];
    end

    psch_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_job   (new_job),
      .left_job  (left_job),
      .left_gt   (gt_vec[i]),
      .right_job (chain[i+1]),
      .job       (chain[i]),
      .gt        (gt_vec[i+1])
    );

    assign valid_vec[i] = chain[i].valid;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign slot_free = !out_valid || out_ready;
  assign last_one  = !chain[1].valid;
  assign head_tat  = elapsed + ELP_W'(chain[0].burst);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && last_job) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_one) begin
          state_next = ST_DSTART;
        end
      end
      ST_DSTART: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy_w && !div_busy_t) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    pop        = 1'b0;
    park       = 1'b0;
    div_start  = 1'b0;
    final_load = 1'b0;
    unique case (state)
      ST_LOAD:   in_ready   = 1'b1;
      ST_EMIT: begin
        // Keep the final job at the head until the averages are ready.
        park = last_one;
        pop  = !last_one && slot_free;
      end
      ST_DSTART: div_start  = 1'b1;
      ST_DIV:    ;
      ST_FINAL:  final_load = slot_free;
      default:   ;
    endcase
  end

  assign accept_in  = in_valid && in_ready;
  assign store      = accept_in && (job_count < CNT_W'(MAX_JOBS));
  assign ctl.insert = store;
  assign ctl.shift  = pop;
  assign ctl.clear  = final_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Batch bookkeeping and running times
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count     <= '0;
      overflow_seen <= 1'b0;
      elapsed       <= '0;
      sum_wait      <= '0;
      sum_tat       <= '0;
    end else if (final_load) begin
      job_count     <= '0;
      overflow_seen <= 1'b0;
      elapsed       <= '0;
      sum_wait      <= '0;
      sum_tat       <= '0;
    end else begin
      if (store) begin
        job_count <= job_count + 1'b1;
      end else if (accept_in) begin
        // Drop the job: the chain is full.
        overflow_seen <= 1'b1;
      end
      if (pop || park) begin
        sum_wait <= sum_wait + SUM_W'(elapsed);
        sum_tat  <= sum_tat + SUM_W'(head_tat);
      end
      if (pop) begin
        elapsed <= head_tat;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Average dividers: 256 * sum / job count
  // --------------------------------------------------------------------------
  psch_div #(
    .DVD_W (DIV_W),
    .DVS_W (CNT_W)
  ) u_div_wait (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_wait, 8'b0}),
    .divisor  (job_count),
    .busy     (div_busy_w),
    .quotient (quo_wait)
  );

  psch_div #(
    .DVD_W (DIV_W),
    .DVS_W (CNT_W)
  ) u_div_tat (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_tat, 8'b0}),
    .divisor  (job_count),
    .busy     (div_busy_t),
    .quotient (quo_tat)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop || final_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || final_load) begin
      job_id          <= chain[0].id[OUT_ID_W-1:0];
      job_priority    <= chain[0].prio;
      job_burst       <= chain[0].burst;
      waiting_time    <= elapsed[TIME_W-1:0];
      turnaround_time <= head_tat[TIME_W-1:0];
      overflow        <= overflow_seen;
      last_result     <= final_load;
      avg_waiting     <= final_load ? quo_wait[AVG_W_W-1:0] : '0;
      avg_turnaround  <= final_load ? quo_tat[AVG_T_W-1:0] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Held jobs always form an unbroken run from the head.
  a_chain_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("gap in job chain");

  // While loading, the chain holds exactly the counted jobs.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ($countones(valid_vec) == job_count))
    else $error("chain occupancy differs from job count");

  // The count never passes capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    job_count <= CNT_W'(MAX_JOBS))
    else $error("job count beyond capacity");

  // Dividers run as soon as they are started.
  a_div_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DSTART) |=> (div_busy_w && div_busy_t))
    else $error("average dividers did not start");

  // Loading the final result reopens the sequencer for a new batch.
  a_final_reload: assert property (@(posedge clk) disable iff (rst)
    final_load |=> (state == ST_LOAD && out_valid && last_result))
    else $error("final result load did not reopen the load phase");

endmodule

`default_nettype wire
